@@ sv/xlsu_pkg.sv @@
// Shared types and constants for the x86 logic and shift unit.
package xlsu_pkg;

   localparam int DATA_BITS = 32;
   localparam int COUNT_BITS = 5;

   typedef enum logic [3:0] {
      OP_TEST  = 4'd0,
      OP_AND   = 4'd1,
      OP_XOR   = 4'd2,
      OP_OR    = 4'd3,
      OP_SAR   = 4'd4,
      OP_SHL   = 4'd5,
      OP_SHR   = 4'd6,
      OP_ROL   = 4'd7,
      OP_SETCC = 4'd8,
      OP_NOT   = 4'd9
   } op_code_type;

   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;

   // condition groups, cond_code[3:1]; cond_code[0] negates
   localparam logic [2:0] COND_O  = 3'd0;
   localparam logic [2:0] COND_B  = 3'd1;
   localparam logic [2:0] COND_Z  = 3'd2;
   localparam logic [2:0] COND_BE = 3'd3;
   localparam logic [2:0] COND_S  = 3'd4;
   localparam logic [2:0] COND_P  = 3'd5;
   localparam logic [2:0] COND_L  = 3'd6;

   typedef struct packed {
      logic                 cf;
      logic                 zf;
      logic                 sf;
      logic                 of;
   } flags_type;

   // one decoded instruction, front to back
   typedef struct packed {
      logic [DATA_BITS-1:0] value;
      logic                 write_back;
      logic                 unsupported;
      logic                 is_setcc;
      logic [3:0]           cond;
      logic                 upd_zs;
      logic                 clr_co;
      logic                 upd_cf;
      logic                 upd_of;
      flags_type            flags;
   } op_type;

endpackage

@@ sv/xlsu_front.sv @@
// Front end: accepts requests and computes values and flag candidates.
module xlsu_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [3:0]                    req_op,
   input  logic [1:0]                    req_width_code,
   input  logic [xlsu_pkg::DATA_BITS-1:0] req_dest_value,
   input  logic [xlsu_pkg::DATA_BITS-1:0] req_src_value,
   input  logic [3:0]                    req_cond_code,
   input  logic                          queue_full,
   output logic                          push,
   output xlsu_pkg::op_type              op
);

   localparam int W = xlsu_pkg::DATA_BITS;

   logic [W-1:0]   mask;
   logic [W-1:0]   d;
   logic [W-1:0]   s;
   logic [xlsu_pkg::COUNT_BITS-1:0] cnt;
   logic [W-1:0]   logic_val;
   logic [W-1:0]   sar_ext;
   logic [W-1:0]   sar_shift;
   logic [W-1:0]   shl_val;
   logic [W-1:0]   shr_val;
   logic [15:0]    rot8;
   logic [31:0]    rot16;
   logic [2*W-1:0] rot32;
   logic [W-1:0]   rol_val;
   logic [W-1:0]   flag_val;

   function automatic logic msb_of(input logic [W-1:0] v, input logic [1:0] code);
      logic r;
      case (code)
         xlsu_pkg::WIDTH_8:  r = v[7];
         xlsu_pkg::WIDTH_16: r = v[15];
         default:            r = v[W-1];
      endcase
      return r;
   endfunction

   assign req_tready = !queue_full;
   assign push = req_tvalid && !queue_full;

   always_comb begin
      case (req_width_code)
         xlsu_pkg::WIDTH_8:  mask = W'(32'h0000_00ff);
         xlsu_pkg::WIDTH_16: mask = W'(32'h0000_ffff);
         default:            mask = '1;
      endcase
   end

   assign d = req_dest_value & mask;
   assign s = req_src_value;
   assign cnt = s[xlsu_pkg::COUNT_BITS-1:0];

   always_comb begin
      case (xlsu_pkg::op_code_type'(req_op))
         xlsu_pkg::OP_XOR: logic_val = d ^ (s & mask);
         xlsu_pkg::OP_OR:  logic_val = d | (s & mask);
         default:          logic_val = d & s;
      endcase
   end

   assign sar_ext = d | (msb_of(d, req_width_code) ? ~mask : '0);
   assign sar_shift = $signed(sar_ext) >>> cnt;
   assign shl_val = (d << cnt) & mask;
   assign shr_val = d >> cnt;

   assign rot8 = {d[7:0], d[7:0]} << s[2:0];
   assign rot16 = {d[15:0], d[15:0]} << s[3:0];
   assign rot32 = {d, d} << s[4:0];

   always_comb begin
      case (req_width_code)
         xlsu_pkg::WIDTH_8:  rol_val = W'(rot8[15:8]);
         xlsu_pkg::WIDTH_16: rol_val = W'(rot16[31:16]);
         default:            rol_val = rot32[2*W-1:W];
      endcase
   end

   always_comb begin
      op = '0;
      op.write_back = 1'b1;
      op.cond = req_cond_code;
      flag_val = '0;
      case (xlsu_pkg::op_code_type'(req_op))
         xlsu_pkg::OP_TEST, xlsu_pkg::OP_AND, xlsu_pkg::OP_XOR, xlsu_pkg::OP_OR: begin
            flag_val = logic_val;
            op.upd_zs = 1'b1;
            op.clr_co = 1'b1;
            if (xlsu_pkg::op_code_type'(req_op) == xlsu_pkg::OP_TEST) begin
               op.write_back = 1'b0;
            end else begin
               op.value = logic_val;
            end
         end
         xlsu_pkg::OP_SAR: begin
            op.value = sar_shift & mask;
            flag_val = sar_shift & mask;
            op.upd_zs = 1'b1;
         end
         xlsu_pkg::OP_SHL: begin
            op.value = shl_val;
            flag_val = shl_val;
            op.upd_zs = 1'b1;
         end
         xlsu_pkg::OP_SHR: begin
            op.value = shr_val;
            flag_val = shr_val;
            op.upd_zs = 1'b1;
         end
         xlsu_pkg::OP_ROL: begin
            op.value = rol_val;
            op.upd_cf = (cnt != '0);
            op.upd_of = (cnt == xlsu_pkg::COUNT_BITS'(1));
            op.flags.cf = rol_val[0];
            op.flags.of = msb_of(rol_val, req_width_code) ^ rol_val[0];
         end
         xlsu_pkg::OP_SETCC: begin
            op.is_setcc = 1'b1;
            if (req_cond_code[3:1] == xlsu_pkg::COND_P) begin
               op.unsupported = 1'b1;
               op.write_back = 1'b0;
            end
         end
         xlsu_pkg::OP_NOT: begin
            op.value = ~d & mask;
         end
         default: begin
            op.write_back = 1'b0;
         end
      endcase
      if (op.upd_zs) begin
         op.flags.zf = (flag_val == '0);
         op.flags.sf = msb_of(flag_val, req_width_code);
      end
   end

endmodule

@@ sv/xlsu_queue.sv @@
// Small FIFO between the decode front end and the flag back end.
module xlsu_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xlsu_pkg::op_type  push_op,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output xlsu_pkg::op_type  head_op
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   xlsu_pkg::op_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");
`endif

endmodule

@@ sv/xlsu_back.sv @@
// Back end: applies flag updates, evaluates conditions, holds the response register.
module xlsu_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  xlsu_pkg::op_type              head_op,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [xlsu_pkg::DATA_BITS-1:0] rsp_result,
   output logic                          rsp_write_back,
   output logic                          rsp_unsupported,
   output xlsu_pkg::flags_type           rsp_flags
);

   localparam int W = xlsu_pkg::DATA_BITS;

   xlsu_pkg::flags_type flags_ff, flags_in;
   logic                out_valid_ff, out_valid_in;
   logic [W-1:0]        result_ff, result_in;
   logic                write_back_ff;
   logic                unsup_ff;
   xlsu_pkg::flags_type out_flags_ff;
   logic                cond_true;
   logic                cond_raw;

   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      case (head_op.cond[3:1])
         xlsu_pkg::COND_O:  cond_raw = flags_ff.of;
         xlsu_pkg::COND_B:  cond_raw = flags_ff.cf;
         xlsu_pkg::COND_Z:  cond_raw = flags_ff.zf;
         xlsu_pkg::COND_BE: cond_raw = flags_ff.cf || flags_ff.zf;
         xlsu_pkg::COND_S:  cond_raw = flags_ff.sf;
         xlsu_pkg::COND_L:  cond_raw = flags_ff.sf != flags_ff.of;
         default:           cond_raw = flags_ff.zf || (flags_ff.sf != flags_ff.of);
      endcase
      cond_true = cond_raw ^ head_op.cond[0];
   end

   always_comb begin
      flags_in = flags_ff;
      if (head_op.upd_zs) begin
         flags_in.zf = head_op.flags.zf;
         flags_in.sf = head_op.flags.sf;
      end
      if (head_op.clr_co) begin
         flags_in.cf = 1'b0;
         flags_in.of = 1'b0;
      end
      if (head_op.upd_cf) begin
         flags_in.cf = head_op.flags.cf;
      end
      if (head_op.upd_of) begin
         flags_in.of = head_op.flags.of;
      end
      if (head_op.is_setcc && !head_op.unsupported) begin
         result_in = W'(cond_true);
      end else begin
         result_in = head_op.value;
      end
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
         write_back_ff <= head_op.write_back;
         unsup_ff <= head_op.unsupported;
         out_flags_ff <= flags_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = result_ff;
   assign rsp_write_back = write_back_ff;
   assign rsp_unsupported = unsup_ff;
   assign rsp_flags = out_flags_ff;

`ifndef SYNTH
   a_flags_reset: assert property (@(posedge clock)
      $past(reset) |-> flags_ff == '0)
      else $error("flags not cleared by reset");
   a_flags_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> $stable(flags_ff))
      else $error("flags changed while response stalled");
   a_unsup_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && unsup_ff |-> result_ff == '0 && !write_back_ff)
      else $error("unsupported condition produced a result");
`endif

endmodule

@@ sv/x86_logic_shift_unit.sv @@
// Top level of the x86 logic and shift unit.
//
// Usage:
//   req channel carries one instruction per transaction; req_tuser is the
//   operation code, req_tdata holds width code, destination, source/count and
//   condition code. rsp channel returns one transaction per instruction, in
//   order: rsp_tdata holds the result and the ZF, SF, CF, OF flags after that
//   instruction, rsp_tuser flags write-back and unsupported conditions.
//   A request accepted at a clock edge is written into the queue at that edge
//   and moves into the response register when the back end pops it (register
//   empty or rsp_tready high), raising rsp_tvalid. Throughput: one transaction
//   per cycle while rsp_tready stays high; the flag update in the back end
//   feeds the next SETcc directly.
//   Reset (synchronous, active high) clears the flags to zero and empties the
//   queue and response register.
//   When rsp_tready is low a valid response holds; the queue keeps
//   taking requests until its QUEUE_DEPTH entries are used, then req_tready
//   drops until the receiver takes a transaction.
module x86_logic_shift_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // width_code[1:0], dest_value[33:2], src_value[65:34],
                                   // cond_code[69:66], zero pad[71:70]
   input  logic [3:0]  req_tuser,  // req_type[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result[31:0], zero_flag[32], sign_flag[33],
                                   // carry_flag[34], overflow_flag[35], zero pad[39:36]
   output logic [1:0]  rsp_tuser   // write_back[0], unsupported[1]
);

   localparam int W = xlsu_pkg::DATA_BITS;

   logic                queue_full;
   logic                push;
   logic                pop;
   logic                head_valid;
   xlsu_pkg::op_type    front_op;
   xlsu_pkg::op_type    head_op;
   logic [W-1:0]        result;
   logic                write_back;
   logic                unsupported;
   xlsu_pkg::flags_type flags;

   xlsu_front u_front (
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_op         (req_tuser),
      .req_width_code (req_tdata[1:0]),
      .req_dest_value (req_tdata[33:2]),
      .req_src_value  (req_tdata[65:34]),
      .req_cond_code  (req_tdata[69:66]),
      .queue_full     (queue_full),
      .push           (push),
      .op             (front_op)
   );

   xlsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (front_op),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   xlsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_op         (head_op),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_result      (result),
      .rsp_write_back  (write_back),
      .rsp_unsupported (unsupported),
      .rsp_flags       (flags)
   );

   assign rsp_tdata = {4'b0000, flags.of, flags.cf, flags.sf, flags.zf, result};
   assign rsp_tuser = {unsupported, write_back};

endmodule
